>>> rtl/core/cau_pkg.sv
package cau_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int CMD_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_CMP  = 4'd4,
    OP_NEG  = 4'd5,
    OP_CONJ = 4'd6,
    OP_INCR = 4'd7,
    OP_DECR = 4'd8,
    OP_INCI = 4'd9,
    OP_DECI = 4'd10
  } op_t;

  // operation class decided by the front end
  typedef enum logic [1:0] {
    CL_SIMPLE = 2'd0,
    CL_MUL    = 2'd1,
    CL_DIV    = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t                     cls;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] a_re;
    logic signed [WORD_W-1:0] a_im;
    logic signed [WORD_W-1:0] b_re;
    logic signed [WORD_W-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] res_re;
    logic signed [WORD_W-1:0] res_im;
    logic                     equal;
    logic                     div_zero;
    logic                     saturated;
  } rsp_t;

endpackage

>>> rtl/core/complex_arith_unit.sv
// Complex ALU on signed Q16.16 operands. A request carries an opcode and
// operands a and b; each gives exactly one response in order. The front end
// registers and classifies requests into a 4-entry queue; the back end is a
// fixed pipeline (products, sums, one restoring-division bit per stage over
// 82 stages, then saturation) that takes one request per cycle, so the
// sustained rate is one request per clock. With no stalls a request passes
// the front register, the queue, two arithmetic stages, 82 division stages
// and the output register before out_tvalid; the division chain is most of
// that path. Backpressure on out_tready stalls the back end as a whole; the
// queue absorbs requests meanwhile.
module complex_arith_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // a_re, a_im, b_re, b_im
  input  logic [3:0]   in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // res_re, res_im
  output logic [2:0]   out_tuser  // equal, div_zero, saturated
);
  logic          f_v, f_r, b_v, b_r;
  cau_pkg::req_t f_q, b_q;
  cau_pkg::rsp_t rsp;

  cau_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tuser), .in_ops(in_tdata),
    .q_valid(f_v), .q_ready(f_r), .q_req(f_q)
  );

  cau_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst_n, .wr_valid(f_v), .wr_ready(f_r), .wr_req(f_q),
    .rd_valid(b_v), .rd_ready(b_r), .rd_req(b_q)
  );

  cau_back u_back (
    .clk, .rst_n, .q_valid(b_v), .q_ready(b_r), .q_req(b_q),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_rsp(rsp)
  );

  assign out_tdata = {rsp.res_im, rsp.res_re};
  assign out_tuser = {rsp.saturated, rsp.div_zero, rsp.equal};
endmodule

>>> rtl/core/cau_front.sv
// Classifies a request into a pipeline register toward the queue.
module cau_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [3:0]      in_cmd,
  input  logic [127:0]    in_ops,
  output logic            q_valid,
  input  logic            q_ready,
  output cau_pkg::req_t   q_req
);
  logic          vld_r;
  cau_pkg::req_t req_r;
  cau_pkg::req_t req_nxt;

  always_comb begin
    req_nxt.cmd  = in_cmd;
    req_nxt.a_re = in_ops[31:0];
    req_nxt.a_im = in_ops[63:32];
    req_nxt.b_re = in_ops[95:64];
    req_nxt.b_im = in_ops[127:96];
    if (in_cmd == cau_pkg::OP_MUL) begin
      req_nxt.cls = cau_pkg::CL_MUL;
    end else if (in_cmd == cau_pkg::OP_DIV) begin
      req_nxt.cls = cau_pkg::CL_DIV;
    end else begin
      req_nxt.cls = cau_pkg::CL_SIMPLE;
    end
  end

  assign in_ready = !vld_r || q_ready;
  assign q_valid  = vld_r;
  assign q_req    = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      req_r <= req_nxt;
    end
  end
endmodule

>>> rtl/core/cau_fifo.sv
// Short queue between front and back.
module cau_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  cau_pkg::req_t wr_req,
  output logic          rd_valid,
  input  logic          rd_ready,
  output cau_pkg::req_t rd_req
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  cau_pkg::req_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_req   = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_req;
  end
endmodule

>>> rtl/core/cau_back.sv
// Execution pipeline. Every request flows through all stages; the stage
// chain advances when the output slot is empty or being taken (global enable).
// s1: products. s2: sums, divisor. s3..: restoring division, one quotient
// bit per stage. Last: saturation and output register.
module cau_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  cau_pkg::req_t q_req,
  output logic          out_valid,
  input  logic          out_ready,
  output cau_pkg::rsp_t out_rsp
);
  localparam int W  = cau_pkg::WORD_W;
  localparam int F  = cau_pkg::FRAC_W;
  localparam int QB = W + F + 2;     // quotient bits computed (covers overflow)
  localparam int NW = 2*W + 2;       // numerator/divisor magnitude width
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic ovld_r;
  cau_pkg::rsp_t orsp_r;
  assign en        = !ovld_r || out_ready;
  assign q_ready   = en;
  assign out_valid = ovld_r;
  assign out_rsp   = orsp_r;

  // ---- stage 1: products
  logic s1_v_r;
  cau_pkg::req_t s1_q_r;
  logic signed [2*W-1:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r, p_cc_r, p_dd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= q_valid;
    if (en) begin
      s1_q_r <= q_req;
      p_ac_r <= q_req.a_re * q_req.b_re;
      p_bd_r <= q_req.a_im * q_req.b_im;
      p_ad_r <= q_req.a_re * q_req.b_im;
      p_bc_r <= q_req.a_im * q_req.b_re;
      p_cc_r <= q_req.b_re * q_req.b_re;
      p_dd_r <= q_req.b_im * q_req.b_im;
    end
  end

  // ---- stage 2: sums
  logic signed [2*W+1:0] mre_c, mim_c, dre_c, dim_c;
  always_comb begin
    mre_c = (2*W+2)'(p_ac_r) - (2*W+2)'(p_bd_r);
    mim_c = (2*W+2)'(p_ad_r) + (2*W+2)'(p_bc_r);
    dre_c = (2*W+2)'(p_ac_r) + (2*W+2)'(p_bd_r);
    dim_c = (2*W+2)'(p_bc_r) - (2*W+2)'(p_ad_r);
  end

  typedef struct packed {
    logic                  v;
    cau_pkg::req_t         q;
    logic signed [2*W+1:0] mre, mim;
    logic                  nre, nim;
    logic [NW-1:0]         den;
    logic [NW-1:0]         rre, rim;   // partial remainders
    logic [NW-1:0]         nmre, nmim; // remaining numerator bits (shifted)
    logic [QB-1:0]         qre, qim;
  } st_t;

  st_t s2_r;
  logic [NW-1:0] mag_re, mag_im;
  assign mag_re = dre_c[2*W+1] ? NW'(-dre_c) : NW'(dre_c);
  assign mag_im = dim_c[2*W+1] ? NW'(-dim_c) : NW'(dim_c);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_r.v <= 1'b0;
    else if (en) s2_r.v <= s1_v_r;
    if (en) begin
      s2_r.q    <= s1_q_r;
      s2_r.mre  <= mre_c;
      s2_r.mim  <= mim_c;
      s2_r.nre  <= dre_c[2*W+1];
      s2_r.nim  <= dim_c[2*W+1];
      s2_r.den  <= NW'(p_cc_r) + NW'(p_dd_r);
      s2_r.rre  <= '0;
      s2_r.rim  <= '0;
      s2_r.nmre <= mag_re;
      s2_r.nmim <= mag_im;
      s2_r.qre  <= '0;
      s2_r.qim  <= '0;
    end
  end

  // ---- division stages: quotient of (num << F) / den, bits from the top.
  // Numerator has NW bits; dividend (num<<F) has NW+F bits. Quotient bits
  // above QB are known to imply overflow, so track them with a sticky flag.
  localparam int DB = NW + F;   // dividend bits = number of steps
  st_t stg_r [DB+1];
  logic big_re_r [DB+1];
  logic big_im_r [DB+1];
  assign stg_r[0] = s2_r;
  assign big_re_r[0] = 1'b0;
  assign big_im_r[0] = 1'b0;

  for (genvar k = 0; k < DB; k++) begin : g_div
    st_t c;
    logic [NW:0] tr, ti;
    logic br, bi;
    always_comb begin
      c  = stg_r[k];
      tr = {c.rre, c.nmre[NW-1]};
      ti = {c.rim, c.nmim[NW-1]};
      br = tr >= {1'b0, c.den};
      bi = ti >= {1'b0, c.den};
      c.rre  = br ? NW'(tr - {1'b0, c.den}) : NW'(tr);
      c.rim  = bi ? NW'(ti - {1'b0, c.den}) : NW'(ti);
      c.nmre = {c.nmre[NW-2:0], 1'b0};
      c.nmim = {c.nmim[NW-2:0], 1'b0};
      c.qre  = {c.qre[QB-2:0], br};
      c.qim  = {c.qim[QB-2:0], bi};
    end
    st_t nx_r;
    logic bgr_r, bgi_r;
    always_ff @(posedge clk) begin
      if (!rst_n) nx_r.v <= 1'b0;
      else if (en) nx_r.v <= stg_r[k].v;
      if (en) begin
        nx_r.q <= c.q; nx_r.mre <= c.mre; nx_r.mim <= c.mim;
        nx_r.nre <= c.nre; nx_r.nim <= c.nim; nx_r.den <= c.den;
        nx_r.rre <= c.rre; nx_r.rim <= c.rim;
        nx_r.nmre <= c.nmre; nx_r.nmim <= c.nmim;
        nx_r.qre <= c.qre; nx_r.qim <= c.qim;
        bgr_r <= big_re_r[k] | stg_r[k].qre[QB-1];
        bgi_r <= big_im_r[k] | stg_r[k].qim[QB-1];
      end
    end
    assign stg_r[k+1]    = nx_r;
    assign big_re_r[k+1] = bgr_r;
    assign big_im_r[k+1] = bgi_r;
  end

  // ---- final stage: select and saturate
  st_t fz;
  assign fz = stg_r[DB];
  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  assign a_re = fz.q.a_re; assign a_im = fz.q.a_im;
  assign b_re = fz.q.b_re; assign b_im = fz.q.b_im;

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v,
                                                 output logic f);
    f = 1'b0;
    if (v > (W+2)'(MAXV)) begin f = 1'b1; return MAXV; end
    if (v < (W+2)'(MINV)) begin f = 1'b1; return MINV; end
    return W'(v);
  endfunction

  function automatic logic signed [W-1:0] sat_m(input logic signed [2*W+1:0] v,
                                                 output logic f);
    logic signed [2*W+1:0] s;
    s = v >>> F;
    f = 1'b0;
    if (s > (2*W+2)'(MAXV)) begin f = 1'b1; return MAXV; end
    if (s < (2*W+2)'(MINV)) begin f = 1'b1; return MINV; end
    return W'(s);
  endfunction

  function automatic logic signed [W-1:0] sat_d(input logic [QB-1:0] q,
                                                 input logic big, input logic ng,
                                                 output logic f);
    logic ov;
    ov = big || (q[QB-1:W] != '0);
    f = 1'b0;
    if (ng) begin
      if (ov || q[W-1:0] > {1'b1, {(W-1){1'b0}}}) begin f = 1'b1; return MINV; end
      return W'(-q[W-1:0]);
    end
    if (ov || q[W-1]) begin f = 1'b1; return MAXV; end
    return W'(q[W-1:0]);
  endfunction

  localparam logic signed [W+1:0] ONE = (W+2)'(1) <<< F;

  cau_pkg::rsp_t r_c;
  logic f1, f2;
  always_comb begin
    r_c = '0;
    f1 = 1'b0;
    f2 = 1'b0;
    unique case (fz.q.cmd)
      cau_pkg::OP_ADD: begin
        r_c.res_re = sat_w((W+2)'(a_re) + (W+2)'(b_re), f1);
        r_c.res_im = sat_w((W+2)'(a_im) + (W+2)'(b_im), f2);
      end
      cau_pkg::OP_SUB: begin
        r_c.res_re = sat_w((W+2)'(a_re) - (W+2)'(b_re), f1);
        r_c.res_im = sat_w((W+2)'(a_im) - (W+2)'(b_im), f2);
      end
      cau_pkg::OP_MUL: begin
        r_c.res_re = sat_m(fz.mre, f1);
        r_c.res_im = sat_m(fz.mim, f2);
      end
      cau_pkg::OP_DIV: begin
        if (fz.den == '0) begin
          r_c.div_zero = 1'b1;
        end else begin
          r_c.res_re = sat_d(fz.qre, big_re_r[DB], fz.nre, f1);
          r_c.res_im = sat_d(fz.qim, big_im_r[DB], fz.nim, f2);
        end
      end
      cau_pkg::OP_CMP: r_c.equal = (a_re == b_re) && (a_im == b_im);
      cau_pkg::OP_NEG: begin
        r_c.res_re = sat_w(-(W+2)'(a_re), f1);
        r_c.res_im = sat_w(-(W+2)'(a_im), f2);
      end
      cau_pkg::OP_CONJ: begin
        r_c.res_re = a_re;
        r_c.res_im = sat_w(-(W+2)'(a_im), f2);
      end
      cau_pkg::OP_INCR: begin
        r_c.res_re = sat_w((W+2)'(a_re) + ONE, f1);
        r_c.res_im = a_im;
      end
      cau_pkg::OP_DECR: begin
        r_c.res_re = sat_w((W+2)'(a_re) - ONE, f1);
        r_c.res_im = a_im;
      end
      cau_pkg::OP_INCI: begin
        r_c.res_re = a_re;
        r_c.res_im = sat_w((W+2)'(a_im) + ONE, f2);
      end
      cau_pkg::OP_DECI: begin
        r_c.res_re = a_re;
        r_c.res_im = sat_w((W+2)'(a_im) - ONE, f2);
      end
      default: r_c = '0;
    endcase
    r_c.saturated = f1 | f2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (en) ovld_r <= fz.v;
    if (en) orsp_r <= r_c;
  end
endmodule

>>> dv/tb_complex_arith_unit.sv
`timescale 1ns / 100ps

module tb_complex_arith_unit;

  // Tracks in-order expected responses; predicts each one from the request operands.
  class cplx_scoreboard;
    cau_pkg::rsp_t pending_rsp[$];
    int   n_err;
    int   n_checked;

    function new();
      n_err     = 0;
      n_checked = 0;
    endfunction

    // clip to signed 32 bits, raising the flag on overflow
    function automatic logic signed [31:0] clip(input logic signed [127:0] v, inout bit f);
      if (v > 128'sd2147483647) begin
        f = 1;
        return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
        f = 1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    // truncated fixed-point quotient of a signed numerator by a positive divisor
    function automatic logic signed [31:0] quot(input logic signed [127:0] num,
                                                input logic [127:0] den, inout bit f);
      logic [127:0] mag;
      logic [127:0] q;
      bit           neg;
      neg = num < 0;
      mag = neg ? -num : num;
      q   = (mag << cau_pkg::FRAC_W) / den;
      if (neg) begin
        if (q > 128'h8000_0000) f = 1;
        return (q >= 128'h8000_0000) ? 32'sh80000000 : -q[31:0];
      end
      if (q >= 128'h8000_0000) begin
        f = 1;
        return 32'sh7fffffff;
      end
      return q[31:0];
    endfunction

    function automatic cau_pkg::rsp_t predict(input logic [3:0] cmd,
                                              input logic signed [31:0] ar,
                                              input logic signed [31:0] ai,
                                              input logic signed [31:0] br,
                                              input logic signed [31:0] bi);
      cau_pkg::rsp_t        r;
      logic signed [127:0]  a, b, c, d, one;
      logic [127:0]         den;
      bit                   st;
      a   = ar;
      b   = ai;
      c   = br;
      d   = bi;
      one = 128'sd1 <<< cau_pkg::FRAC_W;
      st  = 0;
      r   = '0;
      case (cmd)
        cau_pkg::OP_ADD: begin
          r.res_re = clip(a + c, st);
          r.res_im = clip(b + d, st);
        end
        cau_pkg::OP_SUB: begin
          r.res_re = clip(a - c, st);
          r.res_im = clip(b - d, st);
        end
        cau_pkg::OP_MUL: begin
          // exact sum, floored to the fraction width
          r.res_re = clip((a * c - b * d) >>> cau_pkg::FRAC_W, st);
          r.res_im = clip((a * d + b * c) >>> cau_pkg::FRAC_W, st);
        end
        cau_pkg::OP_DIV: begin
          den = c * c + d * d;
          if (den == 0) r.div_zero = 1;
          else begin
            r.res_re = quot(a * c + b * d, den, st);
            r.res_im = quot(c * b - a * d, den, st);
          end
        end
        cau_pkg::OP_CMP:  r.equal = (ar == br) && (ai == bi);
        cau_pkg::OP_NEG: begin
          r.res_re = clip(-a, st);
          r.res_im = clip(-b, st);
        end
        cau_pkg::OP_CONJ: begin
          r.res_re = clip(a, st);
          r.res_im = clip(-b, st);
        end
        cau_pkg::OP_INCR: begin
          r.res_re = clip(a + one, st);
          r.res_im = clip(b, st);
        end
        cau_pkg::OP_DECR: begin
          r.res_re = clip(a - one, st);
          r.res_im = clip(b, st);
        end
        cau_pkg::OP_INCI: begin
          r.res_re = clip(a, st);
          r.res_im = clip(b + one, st);
        end
        cau_pkg::OP_DECI: begin
          r.res_re = clip(a, st);
          r.res_im = clip(b - one, st);
        end
        default: ;
      endcase
      r.saturated = st;
      return r;
    endfunction

    function void note_request(input logic [3:0] cmd, input logic [127:0] data);
      pending_rsp.push_back(predict(cmd, data[31:0], data[63:32], data[95:64], data[127:96]));
    endfunction

    function void check_response(input logic [63:0] data, input logic [2:0] user);
      cau_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: data=%h user=%b", data, user);
        n_err++;
        return;
      end
      e = pending_rsp.pop_front();
      n_checked++;
      if (data[31:0] !== e.res_re) begin
        $error("res_re: expected %h, got %h", e.res_re, data[31:0]);
        n_err++;
      end
      if (data[63:32] !== e.res_im) begin
        $error("res_im: expected %h, got %h", e.res_im, data[63:32]);
        n_err++;
      end
      if (user[0] !== e.equal) begin
        $error("equal: expected %b, got %b", e.equal, user[0]);
        n_err++;
      end
      if (user[1] !== e.div_zero) begin
        $error("div_zero: expected %b, got %b", e.div_zero, user[1]);
        n_err++;
      end
      if (user[2] !== e.saturated) begin
        $error("saturated: expected %b, got %b", e.saturated, user[2]);
        n_err++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;  // a_re, a_im, b_re, b_im
  logic [3:0]   in_tuser;  // cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata; // res_re, res_im
  logic [2:0]   out_tuser; // equal, div_zero, saturated

  cplx_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int n_sent;
  int cycle_cnt;

  complex_arith_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // response side: random stalls plus an optional long hold-off
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata, out_tuser);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one request; valid stays high across back-to-back requests
  task automatic send_req(input logic [3:0] cmd, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {bi, br, ai, ar};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, {bi, br, ai, ar});
    n_sent++;
  endtask

  // operand mix: full-range words, small values near zero, extremes, and zero or single-bit words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(16 << 16)) - (8 << 16);
      7:          return $signed($urandom_range(64)) - 32;
      8:          return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default:    return $urandom_range(1) ? 32'h0 : (32'h1 << $urandom_range(31));
    endcase
  endfunction

  task automatic rand_burst(input int n);
    logic [3:0]  cmd;
    logic [31:0] ar, ai, br, bi;
    repeat (n) begin
      cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
      ar  = rand_word();
      ai  = rand_word();
      br  = rand_word();
      bi  = rand_word();
      // give compare a fair chance of a match, divide of a zero divisor
      if (cmd == cau_pkg::OP_CMP && $urandom_range(1)) begin
        br = ar;
        bi = ai;
      end
      if (cmd == cau_pkg::OP_DIV && $urandom_range(9) == 0) begin
        br = 0;
        bi = 0;
      end
      send_req(cmd, ar, ai, br, bi);
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 0;
    in_tvalid      = 0;
    in_tdata       = '0;
    in_tuser       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    n_sent         = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_req(cau_pkg::OP_ADD,  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_req(cau_pkg::OP_ADD,  32'h00010000, 32'hffff0000, 32'h00008000, 32'h00000001);
    send_req(cau_pkg::OP_SUB,  32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_req(cau_pkg::OP_MUL,  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    // floors to -1 lsb
    send_req(cau_pkg::OP_MUL,  32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000);
    send_req(cau_pkg::OP_MUL,  32'h00020000, 32'h00030000, 32'hffff0000, 32'h00008000);
    // zero divisor
    send_req(cau_pkg::OP_DIV,  32'h00050000, 32'h00030000, 32'h00000000, 32'h00000000);
    send_req(cau_pkg::OP_DIV,  32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000);
    // overflow
    send_req(cau_pkg::OP_DIV,  32'h7fffffff, 32'h00000000, 32'h00000001, 32'h00000000);
    // exact min
    send_req(cau_pkg::OP_DIV,  32'h80000000, 32'h00000000, 32'h00010000, 32'h00000000);
    send_req(cau_pkg::OP_DIV,  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    // trunc toward 0
    send_req(cau_pkg::OP_DIV,  32'hfffffff9, 32'h00000000, 32'h00030000, 32'h00000000);
    send_req(cau_pkg::OP_CMP,  32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0);
    send_req(cau_pkg::OP_CMP,  32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1);
    send_req(cau_pkg::OP_NEG,  32'h80000000, 32'h00010000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_CONJ, 32'h00010000, 32'h80000000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_INCR, 32'h7fffffff, 32'h00000005, 32'h0, 32'h0);
    send_req(cau_pkg::OP_DECR, 32'h80000000, 32'h00000005, 32'h0, 32'h0);
    send_req(cau_pkg::OP_INCI, 32'h00000003, 32'h7fff0000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_DECI, 32'h00000003, 32'h80000000, 32'h0, 32'h0);
    send_req(4'd11,   32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_req(4'd15,   32'h7fffffff, 32'h80000000, 32'h1, 32'h1);

    // random traffic over idle/stall phases
    rand_burst(100);
    // long hold-off so the queue and pipeline back up into in_tready
    hold_cycles = 400;
    rand_burst(60);
    send_idle_pct = 83;
    rand_burst(160);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    rand_burst(160);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    rand_burst(170);
    in_tvalid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d responses checked across all ops and stall mixes",
             n_sent, sb.n_checked);
    if (sb.n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_fifo.sv
rtl/core/cau_back.sv
rtl/core/complex_arith_unit.sv
dv/tb_complex_arith_unit.sv
